// ===== src/cnorm_pkg.sv =====
// ----------------------------------------------------------------------------
// cnorm_pkg
// Shared widths, types and the pipeline control bundle for the chromaticity
// normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cnorm_pkg;

    // Channel and arithmetic widths.
    localparam int CHAN_W    = 8;
    localparam int NUM_LANES = 3;
    localparam int SUM_W     = 10;              // 3 * 255 = 765
    localparam int REM_W     = SUM_W;           // remainder stays below the divisor
    localparam int DIV_STEPS = CHAN_W;          // one quotient bit per stage
    localparam int OUT_STAGE = DIV_STEPS + 1;   // index of the output register
    localparam int DATA_W    = NUM_LANES * CHAN_W;

    // Lane order inside tdata, lowest bits first.
    localparam int LANE_BLUE  = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_RED   = 2;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [REM_W-1:0]  rem_t;

    // Control bundle from the shared control pipeline to the lanes and the
    // merge stage: per-stage load enables, the divisor seen by each divide
    // step, and the black flag in the last divide stage.
    typedef struct packed {
        logic [OUT_STAGE:0]          adv;
        sum_t [DIV_STEPS-1:0]        divisor;
        logic                        black;
    } pipe_ctrl_t;

endpackage : cnorm_pkg

`default_nettype wire

// ===== src/cnorm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cnorm_ctrl
// Valid and ready chain of the pipeline, plus the channel sum and black flag
// that travel alongside the lane data.
// ----------------------------------------------------------------------------
`default_nettype none

module cnorm_ctrl
    import cnorm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire chan_t      blue_in,
    input  wire chan_t      green_in,
    input  wire chan_t      red_in,
    input  wire logic       m_tready,
    output logic            s_tready,
    output logic            m_tvalid,
    output pipe_ctrl_t      ctrl
);

    logic [OUT_STAGE:0]   valid_reg;
    logic [OUT_STAGE:0]   valid_next;
    logic [OUT_STAGE:0]   adv;
    sum_t [DIV_STEPS-1:0] div_reg;
    logic [DIV_STEPS:0]   black_reg;
    sum_t                 sum;

    assign sum = {2'b00, blue_in} + {2'b00, green_in} + {2'b00, red_in};

    // A stage can load when it is empty or when the stage after it moves on.
    always_comb begin
        adv[OUT_STAGE] = !valid_reg[OUT_STAGE] || m_tready;
        for (int k = OUT_STAGE - 1; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    // Next valid bits: a loading stage takes the valid bit of the one before.
    always_comb begin
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k <= OUT_STAGE; k++) begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Divisor and black flag follow the item through the divide stages.
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            div_reg[0]   <= sum;
            black_reg[0] <= (sum == '0);
        end
        for (int k = 1; k < DIV_STEPS; k++) begin
            if (adv[k]) begin
                div_reg[k] <= div_reg[k-1];
            end
        end
        for (int k = 1; k <= DIV_STEPS; k++) begin
            if (adv[k]) begin
                black_reg[k] <= black_reg[k-1];
            end
        end
    end

    assign s_tready     = adv[0];
    assign m_tvalid     = valid_reg[OUT_STAGE];
    assign ctrl.adv     = adv;
    assign ctrl.divisor = div_reg;
    assign ctrl.black   = black_reg[DIV_STEPS];

endmodule : cnorm_ctrl

`default_nettype wire

// ===== src/cnorm_lane.sv =====
// ----------------------------------------------------------------------------
// cnorm_lane
// One channel lane: forms channel * 255 and divides it by the channel sum in
// a pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cnorm_lane
    import cnorm_pkg::*;
(
    input  wire logic       aclk,
    input  wire chan_t      chan_in,
    input  wire pipe_ctrl_t ctrl,
    output chan_t           quot
);

    localparam int PROD_W = 2 * CHAN_W;

    rem_t  rem_reg [DIV_STEPS+1];
    chan_t lq_reg  [DIV_STEPS+1];
    rem_t  rem_next [DIV_STEPS+1];
    chan_t lq_next  [DIV_STEPS+1];
    logic [PROD_W-1:0] prod;

    // channel * 255 as (channel << 8) - channel.
    assign prod = {chan_in, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, chan_in};

    // The quotient fits in eight bits, so the upper product byte already is
    // below the divisor and starts as the partial remainder. The lower byte
    // is shifted in one bit per step while quotient bits shift in behind it.
    always_comb begin
        logic [REM_W:0] shifted;
        logic [REM_W:0] diff;
        logic           ge;
        rem_next[0] = {{(REM_W-CHAN_W){1'b0}}, prod[PROD_W-1:CHAN_W]};
        lq_next[0]  = prod[CHAN_W-1:0];
        for (int k = 1; k <= DIV_STEPS; k++) begin
            shifted     = {rem_reg[k-1], lq_reg[k-1][CHAN_W-1]};
            diff        = shifted - {1'b0, ctrl.divisor[k-1]};
            ge          = (shifted >= {1'b0, ctrl.divisor[k-1]});
            rem_next[k] = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            lq_next[k]  = {lq_reg[k-1][CHAN_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k <= DIV_STEPS; k++) begin
            if (ctrl.adv[k]) begin
                rem_reg[k] <= rem_next[k];
                lq_reg[k]  <= lq_next[k];
            end
        end
    end

    assign quot = lq_reg[DIV_STEPS];

endmodule : cnorm_lane

`default_nettype wire

// ===== src/cnorm_merge.sv =====
// ----------------------------------------------------------------------------
// cnorm_merge
// Output register: gathers the three lane quotients and the black flag into
// one result transfer, forcing the channels to zero for a black pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module cnorm_merge
    import cnorm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire chan_t [NUM_LANES-1:0]  quot,
    input  wire pipe_ctrl_t             ctrl,
    output logic [DATA_W-1:0]           m_tdata,
    output logic [0:0]                  m_tuser
);

    logic [DATA_W-1:0] data_reg;
    logic              black_reg;

    // Load the result when the output register is free or being drained.
    always_ff @(posedge aclk) begin
        if (ctrl.adv[OUT_STAGE]) begin
            black_reg <= ctrl.black;
            if (ctrl.black) begin
                data_reg <= '0;
            end else begin
                data_reg <= {quot[LANE_RED], quot[LANE_GREEN], quot[LANE_BLUE]};
            end
        end
    end

    assign m_tdata = data_reg;
    assign m_tuser = black_reg;

endmodule : cnorm_merge

`default_nettype wire

// ===== src/chromaticity_normalizer.sv =====
// ----------------------------------------------------------------------------
// chromaticity_normalizer
// Normalized RGB chromaticity: each channel becomes floor(channel*255/sum).
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one pixel per transfer: blue, green and red bytes
//   in s_tdata. The master channel returns one result per pixel, in order:
//   the three normalized bytes in m_tdata and the black-pixel flag in m_tuser.
//   A pixel whose channel sum is zero returns all-zero bytes with the flag set.
//   Three lanes, one per channel, each divide channel*255 by the shared sum in
//   an eight-stage pipelined restoring divider, one quotient bit per stage;
//   a merge stage then registers the combined result.
//   Throughput is one pixel per cycle while the receiver keeps m_tready high.
//   The pipeline has ten stages: the operand stage, the eight divide stages
//   and the output register.
//   When the receiver stalls, each stage holds its item and empty stages
//   still fill, so s_tready drops only once all ten stages are occupied.
//   A synchronous active-low reset clears the valid bits, so it empties the
//   pipeline: pixels inside are dropped, none is invented; data is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module chromaticity_normalizer
    import cnorm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Slave channel.
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [DATA_W-1:0]  s_tdata,   // [7:0] blue_in, [15:8] green_in, [23:16] red_in
    // Master channel.
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [DATA_W-1:0]       m_tdata,   // [7:0] blue_out, [15:8] green_out, [23:16] red_out
    output logic [0:0]              m_tuser    // [0] black_pixel
);

    pipe_ctrl_t            ctrl;
    chan_t [NUM_LANES-1:0] chan;
    chan_t [NUM_LANES-1:0] quot;

    assign chan = s_tdata;

    // Handshake chain, channel sum and black flag.
    cnorm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .blue_in  (chan[LANE_BLUE]),
        .green_in (chan[LANE_GREEN]),
        .red_in   (chan[LANE_RED]),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .ctrl     (ctrl)
    );

    // One divider lane per channel.
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        cnorm_lane u_lane (
            .aclk    (aclk),
            .chan_in (chan[i]),
            .ctrl    (ctrl),
            .quot    (quot[i])
        );
    end

    // Result register.
    cnorm_merge u_merge (
        .aclk    (aclk),
        .quot    (quot),
        .ctrl    (ctrl),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule : chromaticity_normalizer

`default_nettype wire

// ===== src/cnorm_checker.sv =====
// ----------------------------------------------------------------------------
// cnorm_checker
// Port-level checks for the chromaticity normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cnorm_checker
    import cnorm_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DATA_W-1:0] m_tdata,
    input wire logic [0:0]        m_tuser
);

    sum_t out_sum;

    // The floors of three shares of 255 lose less than one each.
    assign out_sum = {2'b00, m_tdata[7:0]} + {2'b00, m_tdata[15:8]}
                   + {2'b00, m_tdata[23:16]};

    // A stalled result transfer holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A black pixel carries zero channels.
    a_black_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("black pixel with nonzero channels");

    // Normalized channels of a non-black pixel add up to 253..255.
    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> out_sum >= 10'd253 && out_sum <= 10'd255)
        else $error("normalized channel sum out of range");

    // With the output register empty the whole pipeline can take a pixel.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule : cnorm_checker

bind chromaticity_normalizer cnorm_checker u_cnorm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/tb_chromaticity_normalizer.sv =====
// ----------------------------------------------------------------------------
// tb_chromaticity_normalizer
// Self-checking testbench for the normalized RGB chromaticity block.
// Pixels go in on the slave stream and each result is checked against a
// local integer model of floor(channel*255/sum) with the black-pixel flag.
// Both stream sides idle at random, and the random pixels are biased toward
// black, dim, single-channel and near-gray values.
// ----------------------------------------------------------------------------
module tb_chromaticity_normalizer;

    timeunit 1ns;
    timeprecision 1ps;

    import cnorm_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 12;
    localparam int CHAN_FULL   = 255;
    localparam int STALL_LIMIT = 4000;   // cycles with no transfer on either side
    localparam int TAIL_CYCLES = 24;     // pipeline depth plus margin

    // One normalized pixel as it appears on the master side.
    typedef struct packed {
        logic  black;
        chan_t red;
        chan_t green;
        chan_t blue;
    } chroma_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;   // [7:0] blue_in, [15:8] green_in, [23:16] red_in
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // [7:0] blue_out, [15:8] green_out, [23:16] red_out
    logic [0:0]        m_tuser;         // [0] black_pixel

    chroma_t pending_pixels[$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    int      src_idle_pct   = 0;
    int      snk_stall_pct  = 0;

    chromaticity_normalizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Integer chromaticity of one pixel; an all-zero pixel raises the flag.
    function automatic chroma_t normalize_pixel(input chan_t b, input chan_t g, input chan_t r);
        chroma_t res;
        int      total;
        res   = '0;
        total = int'(b) + int'(g) + int'(r);
        if (total == 0) begin
            res.black = 1'b1;
        end else begin
            res.blue  = chan_t'((int'(b) * CHAN_FULL) / total);
            res.green = chan_t'((int'(g) * CHAN_FULL) / total);
            res.red   = chan_t'((int'(r) * CHAN_FULL) / total);
        end
        return res;
    endfunction

    // Random pixel with a bias toward the corners of the color space.
    function automatic void pick_pixel(output chan_t b, output chan_t g, output chan_t r);
        chan_t base;
        b = chan_t'($urandom);
        g = chan_t'($urandom);
        r = chan_t'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                b = '0; g = '0; r = '0;
            end
            1: begin
                // Each channel is cleared with odds of two in three, often leaving one lit.
                if ($urandom_range(0, 2) != 0) b = '0;
                if ($urandom_range(0, 2) != 0) g = '0;
                if ($urandom_range(0, 2) != 0) r = '0;
            end
            2: begin
                b = chan_t'($urandom_range(0, 3));
                g = chan_t'($urandom_range(0, 3));
                r = chan_t'($urandom_range(0, 3));
            end
            3: begin
                // Near gray, often near full scale.
                base = chan_t'($urandom_range(200, 255));
                b = base - chan_t'($urandom_range(0, 2));
                g = base - chan_t'($urandom_range(0, 2));
                r = base - chan_t'($urandom_range(0, 2));
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    // Offer one pixel, idling at random first, and log its expected result
    // at the edge where the transfer happens.
    task automatic send_pixel(input chan_t b, input chan_t g, input chan_t r);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= DATA_W'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, g, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_pixels.push_back(normalize_pixel(b, g, r));
    endtask

    task automatic test_directed();
        send_pixel(8'd0,   8'd0,   8'd0);     // black pixel
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd0,   8'd0,   8'd0);     // black pixel again
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd1,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd170, 8'd85,  8'd0);
        send_pixel(8'd128, 8'd64,  8'd32);
        send_pixel(8'd127, 8'd128, 8'd1);
    endtask

    task automatic test_random_pixels(input int count, input int src_pct, input int snk_pct);
        chan_t b, g, r;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        repeat (count) begin
            pick_pixel(b, g, r);
            send_pixel(b, g, r);
        end
    endtask

    // A burst, then the sender holds off until the pipeline has drained.
    task automatic test_drain_pause();
        chan_t b, g, r;
        repeat (12) begin
            pick_pixel(b, g, r);
            send_pixel(b, g, r);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    // Receiver readiness changes at random on every edge.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge aclk) begin : check_results
        chroma_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with none pending", 0, m_tdata);
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[7:0] !== want.blue)
                    report_mismatch("blue_out", want.blue, m_tdata[7:0]);
                if (m_tdata[15:8] !== want.green)
                    report_mismatch("green_out", want.green, m_tdata[15:8]);
                if (m_tdata[23:16] !== want.red)
                    report_mismatch("red_out", want.red, m_tdata[23:16]);
                if (m_tuser[0] !== want.black)
                    report_mismatch("black_pixel", want.black, m_tuser[0]);
            end
        end
    end

    // End the run if no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        src_idle_pct  = 21;
        snk_stall_pct = 88;
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_pixels(420, 21, 88);
        test_drain_pause();
        test_random_pixels(420, 88, 21);
        test_drain_pause();
        test_random_pixels(420, 0, 0);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== chromaticity_normalizer.f =====
src/cnorm_pkg.sv
src/cnorm_ctrl.sv
src/cnorm_lane.sv
src/cnorm_merge.sv
src/chromaticity_normalizer.sv
src/cnorm_checker.sv
tb/tb_chromaticity_normalizer.sv
